// ===== rtl/lmfds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Lamp sequencer package
// Shared types, codes and timing constants of the lamp mode sequencer.
// ----------------------------------------------------------------------------
package lmfds_pkg;

    // Width of the PWM duty path; the targets use their low DUTY_BITS bits.
    localparam int DUTY_BITS = 16;

    localparam int MODE_W      = 3;
    localparam int KIND_W      = 2;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int STEP_W      = 16;
    localparam int ON_TIME_W   = 18;
    localparam int FLASH_W     = 15;
    localparam int PHASE_W     = 10;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd2;

    // Modes
    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_YELLOW = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WHITE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BOTH   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLASH  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_CHARGE_TARGET = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NORMAL_TARGET = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHARGE_STEP   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_NORMAL_STEP   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD          = 3'd4;

    localparam logic [STEP_W-1:0]    CHARGE_STEP_RST = 16'd10;
    localparam logic [STEP_W-1:0]    NORMAL_STEP_RST = 16'd100;
    localparam logic [ON_TIME_W-1:0] HOLD_RST        = 18'(180 * 1000);

    localparam logic [ON_TIME_W-1:0] ON_TIME_MAX = '1;
    localparam logic [STEP_W-1:0]    STEP_MAX    = '1;

    // Flash show timing, in ticks
    localparam logic [FLASH_W-1:0] SHOW1_END  = 15'd7800;
    localparam logic [FLASH_W-1:0] SHOW2_END  = 15'(7800 + 4260);
    localparam logic [FLASH_W-1:0] SHOW3_END  = 15'(7800 + 4260 + 6170);
    localparam logic [FLASH_W-1:0] SHOW3_DARK = 15'(7800 + 4260 + 230);
    localparam logic [FLASH_W-1:0] SHOW2_FIRST = 15'(7800 + 1);

    localparam logic [PHASE_W-1:0] SHOW1_PERIOD = 10'd800;
    localparam logic [PHASE_W-1:0] SHOW1_BLUE_END = 10'd200;
    localparam logic [PHASE_W-1:0] SHOW1_RED_BEGIN = 10'd400;
    localparam logic [PHASE_W-1:0] SHOW1_RED_END = 10'd600;
    localparam logic [PHASE_W-1:0] SHOW2_PERIOD = 10'(230 + 220);
    localparam logic [PHASE_W-1:0] SHOW2_ON_END = 10'd230;
    localparam logic [PHASE_W-1:0] SHOW3_PERIOD = 10'd600;
    localparam logic [PHASE_W-1:0] SHOW3_HALF   = 10'd300;
    localparam logic [PHASE_W-1:0] BLINK_PERIOD = 10'(40 + 60);
    localparam logic [PHASE_W-1:0] BLINK_ON     = 10'd40;

    typedef struct packed {
        logic [DUTY_BITS-1:0] charge_target;
        logic [DUTY_BITS-1:0] normal_target;
        logic [STEP_W-1:0]    charge_step;
        logic [STEP_W-1:0]    normal_step;
        logic [ON_TIME_W-1:0] hold;
    } cfg_t;

    // Per-word control from the decode stage; enter and the tick strobes are already qualified by the fire strobe
    typedef struct packed {
        logic tick_flash;
        logic tick_ramp;
        logic enter;
        logic enter_flash;
        logic charging;
    } ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/lamp_mode_flash_and_dimming_sequencer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Lamp mode, flash and dimming sequencer
// Five-mode lamp controller with a red/blue flash show and a PWM duty ramp.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one word per event: a 1 ms tick, a button press
//   or a direct mode set (kind in s_tuser). Every accepted word gives exactly
//   one result word on the master channel with the mode, lamp enables, PWM
//   duty and indicator state as they stand after that event.
//   A word is registered on entry and processed when its result is loaded into
//   the output register, which waits while the receiver stalls; one word per
//   cycle is sustained while the receiver takes every word, set by the single
//   processing stage between the input and output registers.
//   If the receiver stalls, the output register holds its word and the input
//   register takes at most one more word before s_tready drops.
//   The configuration port writes one register per cycle with no wait; the
//   user must write it only while no word is in flight (not enforced here).
//   Reset puts the block in off mode with all counters and the duty at zero
//   and loads the register defaults.
// ----------------------------------------------------------------------------
module lamp_mode_flash_and_dimming_sequencer_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata, lowest bit up: mode_request[2:0], charging, zero pad
    input  wire logic [7:0]                      s_tdata,
    // s_tuser: kind[1:0]
    input  wire logic [lmfds_pkg::KIND_W-1:0]    s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // m_tdata, lowest bit up: mode[2:0], yellow_enable, white_enable,
    // duty[15:0], red_on, blue_on, zero pad
    output logic [23:0]                          m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_wr_en,
    input  wire logic [lmfds_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [lmfds_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lmfds_pkg::*;

    cfg_t  cfg;
    ctrl_t ctrl;

    logic              in_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [MODE_W-1:0] req_reg;
    logic              chg_reg;

    logic [MODE_W-1:0] mode_reg, mode_next, mode_target;
    logic              out_free, fire, is_tick, enter;

    logic                 red_next, blue_next;
    logic [DUTY_BITS-1:0] duty_next;

    logic              m_valid_reg;
    logic [MODE_W-1:0] out_mode_reg;
    logic              out_yellow_reg, out_white_reg, out_red_reg, out_blue_reg;
    logic [15:0]       out_duty_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg <= s_tuser;
            req_reg  <= s_tdata[MODE_W-1:0];
            chg_reg  <= s_tdata[MODE_W];
        end
    end

    // Mode decode
    always_comb begin
        is_tick     = (kind_reg == KIND_TICK);
        mode_target = (mode_reg >= MODE_FLASH) ? MODE_OFF : mode_reg + 1'b1;
        enter       = 1'b0;
        case (kind_reg)
            KIND_PRESS: enter = 1'b1;
            KIND_SET: begin
                enter       = (req_reg <= MODE_FLASH);
                mode_target = req_reg;
            end
            default: ;
        endcase
        enter     = fire && enter;
        mode_next = enter ? mode_target : mode_reg;

        ctrl.enter       = enter;
        ctrl.enter_flash = (mode_target == MODE_FLASH);
        ctrl.tick_flash  = fire && is_tick && (mode_reg == MODE_FLASH);
        ctrl.tick_ramp   = fire && is_tick && (mode_reg >= MODE_YELLOW)
                           && (mode_reg <= MODE_BOTH);
        ctrl.charging    = chg_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_OFF;
        end else begin
            mode_reg <= mode_next;
        end
    end

    lmfds_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lmfds_flash u_flash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .red_next  (red_next),
        .blue_next (blue_next)
    );

    lmfds_ramp u_ramp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .cfg       (cfg),
        .duty_next (duty_next)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_mode_reg   <= mode_next;
            out_yellow_reg <= (mode_next == MODE_YELLOW) || (mode_next == MODE_BOTH);
            out_white_reg  <= (mode_next == MODE_WHITE) || (mode_next == MODE_BOTH);
            out_duty_reg   <= 16'(duty_next);
            out_red_reg    <= red_next;
            out_blue_reg   <= blue_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_blue_reg, out_red_reg, out_duty_reg,
                       out_white_reg, out_yellow_reg, out_mode_reg};

endmodule
`default_nettype wire

// ===== rtl/lmfds_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Lamp sequencer configuration registers
// Write-only register file for targets, step periods and hold time.
// ----------------------------------------------------------------------------
module lmfds_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [lmfds_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [lmfds_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output lmfds_pkg::cfg_t                      cfg
);
    import lmfds_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.charge_target <= '0;
            cfg_reg.normal_target <= '0;
            cfg_reg.charge_step   <= CHARGE_STEP_RST;
            cfg_reg.normal_step   <= NORMAL_STEP_RST;
            cfg_reg.hold          <= HOLD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_CHARGE_TARGET: cfg_reg.charge_target <= cfg_wdata[DUTY_BITS-1:0];
                CFG_NORMAL_TARGET: cfg_reg.normal_target <= cfg_wdata[DUTY_BITS-1:0];
                CFG_CHARGE_STEP:   cfg_reg.charge_step   <= cfg_wdata[STEP_W-1:0];
                CFG_NORMAL_STEP:   cfg_reg.normal_step   <= cfg_wdata[STEP_W-1:0];
                CFG_HOLD:          cfg_reg.hold          <= cfg_wdata[ON_TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/lmfds_flash.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Lamp sequencer flash show
// Show timer and red/blue indicator state for the flash mode.
// ----------------------------------------------------------------------------
module lmfds_flash (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire lmfds_pkg::ctrl_t ctrl,
    output logic                 red_next,
    output logic                 blue_next
);
    import lmfds_pkg::*;

    localparam logic [PHASE_W-1:0] BLINK_SECOND = PHASE_W'(2 * BLINK_PERIOD);

    logic [FLASH_W-1:0] count_reg, count_next, count_inc;
    logic [PHASE_W-1:0] phase_reg, phase_next, phase_inc, phase_wrap, blink_pos;
    logic               red_reg, blue_reg, blink;

    // The phase register tracks the show timer modulo the period of the
    // current pattern, so no divider is needed.
    always_comb begin
        count_inc  = count_reg + 1'b1;
        if (count_inc <= SHOW1_END) begin
            phase_wrap = SHOW1_PERIOD - 1'b1;
        end else if (count_inc <= SHOW2_END) begin
            phase_wrap = SHOW2_PERIOD - 1'b1;
        end else begin
            phase_wrap = SHOW3_PERIOD - 1'b1;
        end
        if (count_inc == SHOW2_FIRST) begin
            phase_inc = PHASE_W'(1);
        end else if (count_inc == SHOW3_DARK) begin
            phase_inc = '0;
        end else if (phase_reg == phase_wrap) begin
            phase_inc = '0;
        end else begin
            phase_inc = phase_reg + 1'b1;
        end

        blink_pos = (phase_inc < SHOW3_HALF) ? phase_inc : phase_inc - SHOW3_HALF;
        blink = (blink_pos < BLINK_ON)
             || (blink_pos >= BLINK_PERIOD && blink_pos < BLINK_PERIOD + BLINK_ON)
             || (blink_pos >= BLINK_SECOND && blink_pos < BLINK_SECOND + BLINK_ON);

        count_next = count_reg;
        phase_next = phase_reg;
        red_next   = red_reg;
        blue_next  = blue_reg;
        if (ctrl.enter) begin
            if (ctrl.enter_flash) begin
                count_next = '0;
                phase_next = '0;
            end else begin
                red_next  = 1'b0;
                blue_next = 1'b0;
            end
        end else if (ctrl.tick_flash) begin
            count_next = count_inc;
            phase_next = phase_inc;
            if (count_inc <= SHOW1_END) begin
                blue_next = phase_inc < SHOW1_BLUE_END;
                red_next  = (phase_inc >= SHOW1_RED_BEGIN) && (phase_inc < SHOW1_RED_END);
            end else if (count_inc <= SHOW2_END) begin
                red_next  = phase_inc < SHOW2_ON_END;
                blue_next = phase_inc < SHOW2_ON_END;
            end else if (count_inc <= SHOW3_END) begin
                if (count_inc < SHOW3_DARK) begin
                    red_next  = 1'b0;
                    blue_next = 1'b0;
                end else if (phase_inc < SHOW3_HALF) begin
                    red_next  = 1'b0;
                    blue_next = blink;
                end else begin
                    blue_next = 1'b0;
                    red_next  = blink;
                end
            end else begin
                // End of the show: one dark tick, then start again.
                red_next   = 1'b0;
                blue_next  = 1'b0;
                count_next = '0;
                phase_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            phase_reg <= '0;
            red_reg   <= 1'b0;
            blue_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            phase_reg <= phase_next;
            red_reg   <= red_next;
            blue_reg  <= blue_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lmfds_ramp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Lamp sequencer dimming ramp
// On-time, step counter and PWM duty ramp for the lamp modes.
// ----------------------------------------------------------------------------
module lmfds_ramp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire lmfds_pkg::ctrl_t               ctrl,
    input  wire lmfds_pkg::cfg_t                cfg,
    output logic [lmfds_pkg::DUTY_BITS-1:0]     duty_next
);
    import lmfds_pkg::*;

    logic [ON_TIME_W-1:0] on_time_reg, on_time_next, on_inc;
    logic [STEP_W-1:0]    step_reg, step_next, step_inc;
    logic [DUTY_BITS-1:0] duty_reg;

    always_comb begin
        on_inc   = (on_time_reg == ON_TIME_MAX) ? on_time_reg : on_time_reg + 1'b1;
        step_inc = (step_reg == STEP_MAX) ? step_reg : step_reg + 1'b1;

        on_time_next = on_time_reg;
        step_next    = step_reg;
        duty_next    = duty_reg;
        if (ctrl.enter) begin
            on_time_next = '0;
            step_next    = '0;
            duty_next    = '0;
        end else if (ctrl.tick_ramp) begin
            on_time_next = on_inc;
            step_next    = step_inc;
            if (ctrl.charging) begin
                if (step_inc >= cfg.charge_step) begin
                    step_next = '0;
                    if (duty_reg < cfg.charge_target) begin
                        duty_next = duty_reg + 1'b1;
                    end
                end
            end else if (duty_reg < cfg.normal_target) begin
                // Hold the ramp at its start until the on-time has passed.
                if (on_inc <= cfg.hold) begin
                    step_next = '0;
                end else if (step_inc >= cfg.normal_step) begin
                    step_next = '0;
                    duty_next = duty_reg + 1'b1;
                end
            end else if (duty_reg > cfg.normal_target) begin
                if (step_inc >= cfg.charge_step) begin
                    step_next = '0;
                    duty_next = duty_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_time_reg <= '0;
            step_reg    <= '0;
            duty_reg    <= '0;
        end else begin
            on_time_reg <= on_time_next;
            step_reg    <= step_next;
            duty_reg    <= duty_next;
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Lamp sequencer testbench
// Sends ticks, button presses and mode sets with random gaps, while the
// receiver stalls at random. Each accepted word is run through a local model
// of the modes, the flash show and the duty ramp. Each result word is checked
// field by field against the oldest expectation. Several register settings
// are used, the extremes among them, followed by a long run in flash mode.
// ----------------------------------------------------------------------------
module tb_top;
    import lmfds_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Flash show boundaries, in ticks since the show started
    localparam int PAT_A_END   = 7800;
    localparam int PAT_B_END   = PAT_A_END + 4260;
    localparam int PAT_C_END   = PAT_B_END + 6170;
    localparam int PAT_C_LIGHT = PAT_B_END + 230;

    localparam int FLASH_LIMIT   = 32767;
    localparam int ON_TICKS_MAX  = 262143;
    localparam int STEP_CNT_MAX  = 65535;
    localparam int DUTY_MASK     = (1 << DUTY_BITS) - 1;
    localparam int QUIET_LIMIT   = 1000;
    localparam int FLASH_RUN     = 810;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [2:0]        req;
        logic              chg;
    } lamp_event_t;

    typedef struct packed {
        logic        blue;
        logic        red;
        logic [15:0] duty;
        logic        white;
        logic        yellow;
        logic [2:0]  mode;
    } lamp_word_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic [7:0]            s_tdata   = '0;
    logic [KIND_W-1:0]     s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    lamp_event_t pending_events[$];
    lamp_word_t  expected_words[$];
    lamp_event_t tx_event;

    // Local copy of the lamp state and of the registers
    logic [2:0] lamp_mode = MODE_OFF;
    int         flash_cnt = 0;
    int         on_ticks  = 0;
    int         step_cnt  = 0;
    int         duty_lvl  = 0;
    bit         red_lit   = 1'b0;
    bit         blue_lit  = 1'b0;
    int         cfg_charge_target = 0;
    int         cfg_normal_target = 0;
    int         cfg_charge_step   = 10;
    int         cfg_normal_step   = 100;
    int         cfg_hold          = 180000;

    int error_count  = 0;
    int tx_gap       = 0;
    int tx_calm      = 0;
    int rx_gap       = 0;
    int rx_calm      = 0;
    int quiet_cycles = 0;

    lamp_mode_flash_and_dimming_sequencer_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 40) $display("ERROR at %0t: %s", $time, what);
    endtask

    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 40);
        return $urandom_range(0, 7);
    endfunction

    function automatic void enter_lamp_mode(input logic [2:0] next_mode);
        on_ticks = 0;
        step_cnt = 0;
        duty_lvl = 0;
        if (next_mode == MODE_FLASH) begin
            flash_cnt = 0;
        end else begin
            red_lit  = 1'b0;
            blue_lit = 1'b0;
        end
        lamp_mode = next_mode;
    endfunction

    // Advances the local state by one accepted word and queues its result.
    task automatic predict_lamp_word(input logic [KIND_W-1:0] kind,
                                     input logic [2:0] req, input logic chg);
        int         ph;
        lamp_word_t want;
        if (kind == KIND_TICK && lamp_mode == MODE_FLASH) begin
            if (flash_cnt < FLASH_LIMIT) flash_cnt++;
            if (flash_cnt <= PAT_A_END) begin
                ph       = flash_cnt % 800;
                blue_lit = (ph < 200);
                red_lit  = (ph >= 400 && ph < 600);
            end else if (flash_cnt <= PAT_B_END) begin
                ph       = (flash_cnt - PAT_A_END) % 450;
                red_lit  = (ph < 230);
                blue_lit = (ph < 230);
            end else if (flash_cnt <= PAT_C_END) begin
                if (flash_cnt < PAT_C_LIGHT) begin
                    red_lit  = 1'b0;
                    blue_lit = 1'b0;
                end else begin
                    ph = (flash_cnt - PAT_C_LIGHT) % 600;
                    if (ph < 300) begin
                        red_lit  = 1'b0;
                        blue_lit = ((ph % 100) < 40);
                    end else begin
                        blue_lit = 1'b0;
                        red_lit  = ((ph % 100) < 40);
                    end
                end
            end else begin
                // One dark tick, then the show starts again.
                red_lit   = 1'b0;
                blue_lit  = 1'b0;
                flash_cnt = 0;
            end
        end else if (kind == KIND_TICK && lamp_mode != MODE_OFF) begin
            if (on_ticks < ON_TICKS_MAX) on_ticks++;
            if (step_cnt < STEP_CNT_MAX) step_cnt++;
            if (chg) begin
                if (step_cnt >= cfg_charge_step) begin
                    step_cnt = 0;
                    if (duty_lvl < cfg_charge_target) duty_lvl++;
                end
            end else if (duty_lvl < cfg_normal_target) begin
                if (on_ticks <= cfg_hold) begin
                    step_cnt = 0;
                end else if (step_cnt >= cfg_normal_step) begin
                    step_cnt = 0;
                    duty_lvl++;
                end
            end else if (duty_lvl > cfg_normal_target) begin
                if (step_cnt >= cfg_charge_step) begin
                    step_cnt = 0;
                    duty_lvl--;
                end
            end
        end else if (kind == KIND_PRESS) begin
            enter_lamp_mode(lamp_mode >= MODE_FLASH ? MODE_OFF : lamp_mode + 3'd1);
        end else if (kind == KIND_SET && req <= MODE_FLASH) begin
            enter_lamp_mode(req);
        end
        want.mode   = lamp_mode;
        want.yellow = (lamp_mode == MODE_YELLOW || lamp_mode == MODE_BOTH);
        want.white  = (lamp_mode == MODE_WHITE || lamp_mode == MODE_BOTH);
        want.duty   = duty_lvl[15:0];
        want.red    = red_lit;
        want.blue   = blue_lit;
        expected_words.push_back(want);
    endtask

    task automatic check_lamp_word(input lamp_word_t got);
        lamp_word_t want;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("result word %h with nothing expected", got));
            return;
        end
        want = expected_words.pop_front();
        if (got.mode != want.mode)
            report_mismatch($sformatf("mode %0d, expected %0d", got.mode, want.mode));
        if (got.yellow != want.yellow)
            report_mismatch($sformatf("yellow %0b, expected %0b", got.yellow, want.yellow));
        if (got.white != want.white)
            report_mismatch($sformatf("white %0b, expected %0b", got.white, want.white));
        if (got.duty != want.duty)
            report_mismatch($sformatf("duty %0d, expected %0d", got.duty, want.duty));
        if (got.red != want.red)
            report_mismatch($sformatf("red %0b, expected %0b", got.red, want.red));
        if (got.blue != want.blue)
            report_mismatch($sformatf("blue %0b, expected %0b", got.blue, want.blue));
    endtask

    // Sender: one word per slot, with a random gap after each.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) predict_lamp_word(s_tuser, s_tdata[2:0], s_tdata[3]);
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0 || pending_events.size() == 0) begin
                    if (tx_gap > 0) tx_gap--;
                    s_tvalid <= 1'b0;
                end else begin
                    tx_event = pending_events.pop_front();
                    s_tuser  <= tx_event.kind;
                    s_tdata  <= {4'b0000, tx_event.chg, tx_event.req};
                    s_tvalid <= 1'b1;
                    tx_gap = draw_gap(tx_calm);
                end
            end
        end
    end

    // Receiver: checks each word, then stalls for a random number of cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_lamp_word(lamp_word_t'(m_tdata[22:0]));
                rx_gap = draw_gap(rx_calm);
            end else if (rx_gap > 0) begin
                rx_gap--;
            end
            m_tready <= (rx_gap == 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_event(input logic [KIND_W-1:0] kind, input logic [2:0] req,
                               input logic chg);
        lamp_event_t ev;
        ev.kind = kind;
        ev.req  = req;
        ev.chg  = chg;
        pending_events.push_back(ev);
    endtask

    // Mostly runs of ticks inside a lamp mode, with the charger switching in
    // runs, now and then a mode change and a little noise.
    task automatic queue_random_events(input int count);
        int   made;
        int   r;
        logic chg_now;
        made    = 0;
        chg_now = 1'($urandom_range(0, 1));
        while (made < count) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 24) == 0) chg_now = ~chg_now;
            if (r < 3) begin
                queue_event(KIND_SET, 3'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
            end else if (r < 4) begin
                queue_event(KIND_SET, 3'($urandom_range(0, 4)), 1'($urandom_range(0, 1)));
            end else if (r < 6) begin
                queue_event(KIND_PRESS, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end else if (r < 7) begin
                // Ignored words: unknown kind or an unknown mode request.
                if ($urandom_range(0, 1) == 0)
                    queue_event(KIND_UNUSED, 3'($urandom_range(0, 7)), chg_now);
                else
                    queue_event(KIND_SET, 3'($urandom_range(5, 7)), chg_now);
                made--;
            end else begin
                queue_event(KIND_TICK, 3'($urandom_range(0, 7)), chg_now);
            end
            made++;
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (pending_events.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_setting(input logic [CFG_ADDR_W-1:0] idx, input int value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        case (idx)
            CFG_CHARGE_TARGET: cfg_charge_target = value & 'hFFFF & DUTY_MASK;
            CFG_NORMAL_TARGET: cfg_normal_target = value & 'hFFFF & DUTY_MASK;
            CFG_CHARGE_STEP:   cfg_charge_step   = value & 'hFFFF;
            CFG_NORMAL_STEP:   cfg_normal_step   = value & 'hFFFF;
            CFG_HOLD:          cfg_hold          = value & 'h3FFFF;
            default: ;
        endcase
    endtask

    task automatic program_settings(input int charge_target, input int normal_target,
                                    input int charge_step, input int normal_step,
                                    input int hold);
        wait_idle();
        repeat (2) @(posedge aclk);
        write_setting(CFG_CHARGE_TARGET, charge_target);
        write_setting(CFG_NORMAL_TARGET, normal_target);
        write_setting(CFG_CHARGE_STEP, charge_step);
        write_setting(CFG_NORMAL_STEP, normal_step);
        write_setting(CFG_HOLD, hold);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int p;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words on the register defaults.
        queue_event(KIND_TICK, 3'd7, 1'b1);
        queue_event(KIND_UNUSED, 3'd5, 1'b0);
        queue_event(KIND_SET, 3'd5, 1'b1);
        queue_event(KIND_SET, 3'd6, 1'b0);
        queue_event(KIND_SET, 3'd7, 1'b1);
        queue_event(KIND_PRESS, 3'd0, 1'b0);
        queue_event(KIND_TICK, 3'd0, 1'b1);
        queue_event(KIND_TICK, 3'd7, 1'b0);
        queue_event(KIND_PRESS, 3'd7, 1'b1);
        queue_event(KIND_PRESS, 3'd2, 1'b0);
        queue_event(KIND_TICK, 3'd3, 1'b1);
        queue_event(KIND_PRESS, 3'd0, 1'b0);
        queue_event(KIND_TICK, 3'd1, 1'b0);
        queue_event(KIND_TICK, 3'd4, 1'b1);
        queue_event(KIND_UNUSED, 3'd7, 1'b1);
        queue_event(KIND_PRESS, 3'd0, 1'b0);
        queue_event(KIND_SET, MODE_FLASH, 1'b0);
        queue_event(KIND_TICK, 3'd0, 1'b0);
        queue_event(KIND_SET, MODE_FLASH, 1'b1);
        queue_event(KIND_TICK, 3'd6, 1'b0);
        queue_event(KIND_SET, MODE_YELLOW, 1'b0);
        queue_event(KIND_SET, MODE_YELLOW, 1'b1);
        queue_event(KIND_SET, MODE_WHITE, 1'b0);
        queue_event(KIND_SET, MODE_BOTH, 1'b1);
        queue_event(KIND_SET, MODE_OFF, 1'b0);

        program_settings(30, 10, 2, 3, 15);
        queue_random_events(120);
        program_settings(0, 0, 0, 0, 0);
        queue_random_events(70);
        program_settings(65535, 0, 0, 65535, 262143);
        queue_random_events(70);
        program_settings(65535, 65535, 1, 1, 0);
        queue_random_events(70);
        program_settings(5, 20, 65535, 2, 262143);
        queue_random_events(70);
        for (p = 0; p < 5; p++) begin
            program_settings($urandom_range(0, 12), $urandom_range(0, 12),
                             $urandom_range(0, 4), $urandom_range(0, 4),
                             $urandom_range(0, 25));
            queue_random_events(70);
        end
        // Bits above the 16-bit registers are written too and must be dropped.
        program_settings($urandom_range(0, 12) | ($urandom_range(0, 3) << 16),
                         $urandom_range(0, 12) | ($urandom_range(0, 3) << 16),
                         $urandom_range(0, 4) | ($urandom_range(0, 3) << 16),
                         $urandom_range(0, 4) | ($urandom_range(0, 3) << 16),
                         $urandom_range(0, 25));
        queue_random_events(70);

        // A run in flash mode past the first wrap of the opening pattern.
        queue_event(KIND_SET, MODE_FLASH, 1'b0);
        for (p = 0; p < FLASH_RUN; p++)
            queue_event(KIND_TICK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        queue_event(KIND_PRESS, 3'd0, 1'b0);

        wait_idle();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== lamp_mode_flash_and_dimming_sequencer_core.f =====
rtl/lmfds_pkg.sv
rtl/lmfds_cfg.sv
rtl/lmfds_flash.sv
rtl/lmfds_ramp.sv
rtl/lamp_mode_flash_and_dimming_sequencer_core.sv
tb/tb_top.sv
